FILE: design/rpn_pkg.sv
// Shared types and codes for the RPN stack evaluator.
// Beat payload structs, operator/status codes, divider request/response.
// No dependencies.
package rpn_pkg;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_OPER = 1'b1;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_UNDERFLW = 3'd2;
  localparam logic [2:0] ST_DIVZERO  = 3'd3;
  localparam logic [2:0] ST_SAT      = 3'd4;
  localparam logic [2:0] ST_HALTED   = 3'd5;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] operand_value;
    logic [2:0]        operator_code;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] top_value;
    logic [6:0]        stack_depth;
    logic [2:0]        status;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        ovf;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

FILE: design/rpn_stack_evaluator.sv
// Reverse Polish evaluator on signed fixed point (FRAC_BITS fraction bits), one item at a
// time: an item is taken only while the sequencer is idle, and each item returns exactly one
// result beat (top value, depth, status). Push, add, subtract and ignored or rejected items
// pass from decode straight to the finish step; multiply adds one registered 32x32 multiply,
// then a rounding step; divide and modulo wait for the shared bit-per-cycle divider
// (32 iterations plus setup and hand-off). A finished result waits in the output register
// while the next item is accepted. The top entry lives in a register; the rest of the stack
// is a memory with one write port and one registered read port that needs no clearing after
// reset. Overflow, underflow and zero divisor halt the block until reset; multiply, divide,
// add and subtract saturate and report it.
// Depends on rpn_pkg, rpn_div, rpn_stk_mem.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 64,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rpn_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rpn_pkg::out_item_t out_data
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [63:0] FRAC_MASK = (64'd1 << FRAC_BITS) - 64'd1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_MUL    = 6'b000100,
    S_MULADJ = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_PUSH = 2'd1,
    ACT_POP  = 2'd2
  } act_t;

  state_t             state_r, state_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic               halted_r, halted_nxt;
  logic [31:0]        top_r, top_nxt;
  rpn_pkg::in_item_t  item_r, item_nxt;
  act_t               act_r, act_nxt;
  logic [2:0]         status_r, status_nxt;
  logic               halt_set_r, halt_set_nxt;
  logic               neg_r, neg_nxt;
  logic signed [63:0] res_r, res_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic               out_valid_r, out_valid_nxt;
  rpn_pkg::out_item_t out_data_r, out_data_nxt;

  logic [31:0]        rd_data;
  logic [DW-1:0]      dm1, dm2;
  logic               wr_en;
  rpn_pkg::div_req_t  div_req;
  rpn_pkg::div_rsp_t  div_rsp;

  logic [31:0]        a_mag, b_mag, ai_mag, bi_mag;
  logic [63:0]        mul_bias;
  logic signed [63:0] mul_sum;
  logic [63:0]        q64, r64;
  logic               sat;
  logic [31:0]        clamped;
  logic               out_free;
  logic [DW-1:0]      depth_fin;
  logic [31:0]        top_fin;
  logic [DW+6:0]      depth_ext;

  assign dm1 = depth_r - DW'(1);
  assign dm2 = depth_r - DW'(2);

  rpn_stk_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (dm1[AW-1:0]),
    .wr_data (top_r),
    .rd_addr (dm2[AW-1:0]),
    .rd_data (rd_data)
  );

  rpn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // left operand comes from memory, right operand is the cached top
  assign a_mag  = rd_data[31] ? (32'd0 - rd_data) : rd_data;
  assign b_mag  = top_r[31] ? (32'd0 - top_r) : top_r;
  assign ai_mag = a_mag >> FRAC_BITS;
  assign bi_mag = b_mag >> FRAC_BITS;

  assign mul_bias = prod_r[63] ? FRAC_MASK : 64'd0;
  assign mul_sum  = prod_r + $signed(mul_bias);

  assign q64 = div_rsp.ovf ? 64'h0000_0001_0000_0000 : {32'd0, div_rsp.quotient};
  assign r64 = {32'd0, div_rsp.remainder};

  assign sat     = !((&res_r[63:31]) || !(|res_r[63:31]));
  assign clamped = sat ? (res_r[63] ? 32'h8000_0000 : 32'h7FFF_FFFF) : res_r[31:0];

  assign out_free = !out_valid_r || !out_stall;
  assign wr_en    = (state_r == S_FINISH) && out_free && (act_r == ACT_PUSH)
                    && (depth_r != '0);

  always_comb begin
    unique case (act_r)
      ACT_PUSH: begin
        depth_fin = depth_r + DW'(1);
        top_fin   = item_r.operand_value;
      end
      ACT_POP: begin
        depth_fin = dm1;
        top_fin   = clamped;
      end
      default: begin
        depth_fin = depth_r;
        top_fin   = top_r;
      end
    endcase
  end

  assign depth_ext = {7'd0, depth_fin};

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    halted_nxt    = halted_r;
    top_nxt       = top_r;
    item_nxt      = item_r;
    act_nxt       = act_r;
    status_nxt    = status_r;
    halt_set_nxt  = halt_set_r;
    neg_nxt       = neg_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = {32'd0, a_mag} << FRAC_BITS;
    div_req.divisor  = b_mag;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        act_nxt      = ACT_NONE;
        status_nxt   = rpn_pkg::ST_OK;
        halt_set_nxt = 1'b0;
        state_nxt    = S_FINISH;
        priority if (halted_r) begin
          status_nxt = rpn_pkg::ST_HALTED;
        end else if (item_r.req_type == rpn_pkg::REQ_PUSH) begin
          if (depth_r >= DW'(STACK_DEPTH)) begin
            status_nxt   = rpn_pkg::ST_OVERFLOW;
            halt_set_nxt = 1'b1;
          end else begin
            act_nxt = ACT_PUSH;
          end
        end else if (item_r.operator_code > rpn_pkg::OP_MOD) begin
          // unknown operator: ignored, reported ok
          act_nxt = ACT_NONE;
        end else if (depth_r < DW'(2)) begin
          status_nxt   = rpn_pkg::ST_UNDERFLW;
          halt_set_nxt = 1'b1;
        end else begin
          unique case (item_r.operator_code)
            rpn_pkg::OP_ADD: begin
              act_nxt = ACT_POP;
              res_nxt = {{32{rd_data[31]}}, rd_data} + {{32{top_r[31]}}, top_r};
            end
            rpn_pkg::OP_SUB: begin
              act_nxt = ACT_POP;
              res_nxt = {{32{rd_data[31]}}, rd_data} - {{32{top_r[31]}}, top_r};
            end
            rpn_pkg::OP_MUL: begin
              act_nxt   = ACT_POP;
              state_nxt = S_MUL;
            end
            rpn_pkg::OP_DIV: begin
              if (top_r == 32'd0) begin
                status_nxt   = rpn_pkg::ST_DIVZERO;
                halt_set_nxt = 1'b1;
              end else begin
                act_nxt       = ACT_POP;
                neg_nxt       = rd_data[31] ^ top_r[31];
                div_req.start = 1'b1;
                state_nxt     = S_DIV;
              end
            end
            default: begin
              // modulo on integer parts; remainder follows the dividend's sign
              if (bi_mag == 32'd0) begin
                status_nxt   = rpn_pkg::ST_DIVZERO;
                halt_set_nxt = 1'b1;
              end else begin
                act_nxt          = ACT_POP;
                neg_nxt          = rd_data[31];
                div_req.dividend = {32'd0, ai_mag};
                div_req.divisor  = bi_mag;
                div_req.start    = 1'b1;
                state_nxt        = S_DIV;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        prod_nxt  = $signed(rd_data) * $signed(top_r);
        state_nxt = S_MULADJ;
      end
      S_MULADJ: begin
        // truncate toward zero
        res_nxt   = mul_sum >>> FRAC_BITS;
        state_nxt = S_FINISH;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if (item_r.operator_code == rpn_pkg::OP_DIV) begin
            res_nxt = neg_r ? -$signed(q64) : $signed(q64);
          end else begin
            res_nxt = (neg_r ? -$signed(r64) : $signed(r64)) <<< FRAC_BITS;
          end
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          depth_nxt  = depth_fin;
          top_nxt    = top_fin;
          halted_nxt = halted_r || halt_set_r;
          out_valid_nxt            = 1'b1;
          out_data_nxt.top_value   = (depth_fin == '0) ? 32'd0 : top_fin;
          out_data_nxt.stack_depth = depth_ext[6:0];
          out_data_nxt.status      = (act_r == ACT_POP && sat) ? rpn_pkg::ST_SAT : status_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r      <= top_nxt;
    item_r     <= item_nxt;
    act_r      <= act_nxt;
    status_r   <= status_nxt;
    halt_set_r <= halt_set_nxt;
    neg_r      <= neg_nxt;
    res_r      <= res_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside divide wait");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FINISH))
    else $error("result beat raised outside finish");

  a_halted_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && halted_r) |-> (act_r == ACT_NONE))
    else $error("stack changed while halted");

endmodule

FILE: design/rpn_div.sv
// Iterative unsigned restoring divider, one quotient bit per cycle.
// 64-bit dividend by 32-bit divisor, 32 iterations; flags quotient >= 2^32.
// Depends on rpn_pkg.
module rpn_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rpn_pkg::div_req_t req,
  output rpn_pkg::div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;

  logic [32:0] trial;
  logic [33:0] diff;
  logic        ge;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = ~diff[33];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = req.dividend[63:32];
      quo_nxt  = req.dividend[31:0];
      dvs_nxt  = req.divisor;
      // high half already >= divisor means the quotient needs more than 32 bits
      ovf_nxt  = (req.dividend[63:32] >= req.divisor);
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    ovf_r <= ovf_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.ovf       = ovf_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

FILE: design/rpn_stk_mem.sv
// Value stack storage below the cached top entry.
// One write port, one read port with registered read data.
// No package dependencies.
module rpn_stk_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
